/* src/egw_pkg.sv */
// Shared types and constants for the event group waiter release unit.
// Used by every module of the block but egw_ram; depends on nothing.
package egw_pkg;

  localparam int MAX_WAITERS    = 16;
  localparam int EVENT_BITS     = 32;
  localparam int TASK_ID_BITS   = 8;
  localparam int CFG_INDEX_BITS = 8;
  localparam int STATUS_BITS    = 3;

  localparam logic TRIG_MODE_ANY = 1'b1;
  localparam logic KIND_LISTEN   = 1'b0;
  localparam logic KIND_TRIGGER  = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RELOAD_MASK = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_ANY = CFG_INDEX_BITS'(1);

  typedef enum logic [STATUS_BITS-1:0] {
    ST_PASSED     = 3'd0,
    ST_BLOCKED    = 3'd1,
    ST_FULL       = 3'd2,
    ST_IGNORED    = 3'd3,
    ST_PARTIAL    = 3'd4,
    ST_FIRED_NONE = 3'd5,
    ST_RELEASED   = 3'd6
  } status_t;

  typedef struct packed {
    logic take;
    logic commit;
    logic fire;
    logic pop_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic release_all;
    logic out_free;
    logic cnt_zero;
  } dp_sts_t;

endpackage

/* src/egw_if.sv */
// Valid/ready channel interfaces for request items and result items.
// Depends on egw_pkg for default widths and the status type.
interface egw_in_if #(
  parameter int EVENT_BITS   = egw_pkg::EVENT_BITS,
  parameter int TASK_ID_BITS = egw_pkg::TASK_ID_BITS
);
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [TASK_ID_BITS-1:0] task_id;
  logic [EVENT_BITS-1:0]   event_mask;

  modport source (output valid, kind, task_id, event_mask, input ready);
  modport sink (input valid, kind, task_id, event_mask, output ready);
endinterface

interface egw_out_if #(
  parameter int EVENT_BITS   = egw_pkg::EVENT_BITS,
  parameter int TASK_ID_BITS = egw_pkg::TASK_ID_BITS
);
  logic                    valid;
  logic                    ready;
  egw_pkg::status_t        status;
  logic [TASK_ID_BITS-1:0] released_task;
  logic [EVENT_BITS-1:0]   pending_events;
  logic                    last;

  modport source (output valid, status, released_task, pending_events, last, input ready);
  modport sink (input valid, status, released_task, pending_events, last, output ready);
endinterface

/* src/egw_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module egw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/egw_ctrl.sv */
// Controller state machine: sequences accept, evaluate and waiter release.
// Depends on egw_pkg for the command and status structs.
module egw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  egw_pkg::dp_sts_t   sts,
  output egw_pkg::ctrl_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.release_all) begin
          cmd.fire   = 1'b1;
          state_next = S_POP;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.pop_out = 1'b1;
          if (sts.cnt_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* src/egw_dp.sv */
// Datapath: configuration, pending mask, waiter stack and result register.
// Depends on egw_pkg and on egw_ram for the waiter stack.
module egw_dp #(
  parameter int MAX_WAITERS  = egw_pkg::MAX_WAITERS,
  parameter int EVENT_BITS   = egw_pkg::EVENT_BITS,
  parameter int TASK_ID_BITS = egw_pkg::TASK_ID_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [egw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [EVENT_BITS-1:0]             cfg_wdata,
  input  logic                              in_kind,
  input  logic [TASK_ID_BITS-1:0]           in_task_id,
  input  logic [EVENT_BITS-1:0]             in_event_mask,
  input  egw_pkg::ctrl_cmd_t                cmd,
  output egw_pkg::dp_sts_t                  sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output egw_pkg::status_t                  out_status,
  output logic [TASK_ID_BITS-1:0]           out_task,
  output logic [EVENT_BITS-1:0]             out_pending,
  output logic                              out_last
);
  localparam int CW = $clog2(MAX_WAITERS + 1);
  localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

  logic [EVENT_BITS-1:0]   reload_mask;
  logic                    trigger_any;
  logic [EVENT_BITS-1:0]   pending;
  logic [CW-1:0]           count;
  logic                    req_kind;
  logic [TASK_ID_BITS-1:0] req_tid;
  logic [EVENT_BITS-1:0]   req_ev;

  logic [EVENT_BITS-1:0]   cleared;
  logic [EVENT_BITS-1:0]   pend_new;
  egw_pkg::status_t        dec_status;
  logic                    dec_release;
  logic [CW-1:0]           cnt_dec;
  logic                    ram_we;
  logic                    ram_re;
  logic [TASK_ID_BITS-1:0] ram_rdata;
  logic                    load;

  assign cleared = pending & ~req_ev;
  assign cnt_dec = count - CW'(1);

  always_comb begin
    dec_status  = egw_pkg::ST_PASSED;
    dec_release = 1'b0;
    pend_new    = pending;
    if (req_kind == egw_pkg::KIND_LISTEN) begin
      if (pending == '0) begin
        dec_status = egw_pkg::ST_PASSED;
        if (count == '0) begin
          pend_new = reload_mask;
        end
      end else if (count < CW'(MAX_WAITERS)) begin
        dec_status = egw_pkg::ST_BLOCKED;
      end else begin
        dec_status = egw_pkg::ST_FULL;
      end
    end else if ((pending & req_ev) == '0) begin
      dec_status = egw_pkg::ST_IGNORED;
    end else if (trigger_any != egw_pkg::TRIG_MODE_ANY && cleared != '0) begin
      dec_status = egw_pkg::ST_PARTIAL;
      pend_new   = cleared;
    end else if (count == '0) begin
      dec_status = egw_pkg::ST_FIRED_NONE;
      pend_new   = '0;
    end else begin
      dec_status  = egw_pkg::ST_RELEASED;
      dec_release = 1'b1;
      pend_new    = '0;
    end
  end

  assign sts.release_all = dec_release;
  assign sts.out_free    = ~out_valid | out_ready;
  assign sts.cnt_zero    = (count == '0);

  assign ram_we = cmd.commit & (dec_status == egw_pkg::ST_BLOCKED);
  assign ram_re = cmd.fire | (cmd.pop_out & (count != '0));
  assign load   = cmd.commit | cmd.pop_out;

  egw_ram #(
    .WIDTH(TASK_ID_BITS),
    .DEPTH(MAX_WAITERS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(req_tid),
    .re   (ram_re),
    .raddr(cnt_dec[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_kind <= in_kind;
      req_tid  <= in_task_id;
      req_ev   <= in_event_mask;
    end
    if (cmd.commit) begin
      out_status  <= dec_status;
      out_task    <= '0;
      out_pending <= pend_new;
      out_last    <= 1'b1;
    end else if (cmd.pop_out) begin
      out_status  <= egw_pkg::ST_RELEASED;
      out_task    <= ram_rdata;
      out_pending <= pending;
      out_last    <= (count == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_mask <= '0;
      trigger_any <= 1'b0;
      pending     <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == egw_pkg::REG_RELOAD_MASK) begin
        reload_mask <= cfg_wdata;
        pending     <= cfg_wdata;
      end else if (cfg_we && cfg_index == egw_pkg::REG_TRIGGER_ANY) begin
        trigger_any <= cfg_wdata[0];
      end
      if (cmd.commit || cmd.fire) begin
        pending <= pend_new;
      end
      if (ram_we) begin
        count <= count + CW'(1);
      end else if (ram_re) begin
        count <= cnt_dec;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

/* src/event_group_waiter_release_unit.sv */
// Top level of the event group waiter release unit.
// Depends on egw_pkg, egw_if, egw_ctrl, egw_dp and egw_ram.
//
//   Channel  Direction  Contents
//   req      in         kind, task_id, event_mask
//   res      out        status, released_task, pending_events, last
//   cfg      in         cfg_we, cfg_index, cfg_wdata (reload mask, trigger mode)
//
// An item is accepted in the idle state and then evaluated in the evaluate state.
// A release first reads the stack when it fires, then delivers one waiter
// per cycle from the stack RAM's single read port while results are taken.
// Reset is synchronous; the stack RAM needs no clearing.
// A stalled result holds in the output register; the next item may be
// accepted meanwhile and waits until the register frees.
module event_group_waiter_release_unit #(
  parameter int MAX_WAITERS  = egw_pkg::MAX_WAITERS,
  parameter int EVENT_BITS   = egw_pkg::EVENT_BITS,
  parameter int TASK_ID_BITS = egw_pkg::TASK_ID_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  egw_in_if.sink                             req,
  egw_out_if.source                          res,
  input  logic                               cfg_we,
  input  logic [egw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [EVENT_BITS-1:0]              cfg_wdata
);
  egw_pkg::ctrl_cmd_t cmd;
  egw_pkg::dp_sts_t   sts;

  egw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  egw_dp #(
    .MAX_WAITERS (MAX_WAITERS),
    .EVENT_BITS  (EVENT_BITS),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_kind      (req.kind),
    .in_task_id   (req.task_id),
    .in_event_mask(req.event_mask),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (res.ready),
    .out_valid    (res.valid),
    .out_status   (res.status),
    .out_task     (res.released_task),
    .out_pending  (res.pending_events),
    .out_last     (res.last)
  );
endmodule

/* src/egw_checker.sv */
// Port-level checker for the event group waiter release unit and its bind.
// Depends on egw_pkg and on the top level's ports.
module egw_checker #(
  parameter int EVENT_BITS   = egw_pkg::EVENT_BITS,
  parameter int TASK_ID_BITS = egw_pkg::TASK_ID_BITS
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    res_valid,
  input logic                    res_ready,
  input logic [2:0]              res_status,
  input logic [TASK_ID_BITS-1:0] res_task,
  input logic [EVENT_BITS-1:0]   res_pending,
  input logic                    res_last
);
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_task))
    else $error("Stalled result changed.");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != egw_pkg::ST_RELEASED |-> res_last)
    else $error("Single result not marked last.");

  a_release_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == egw_pkg::ST_RELEASED || res_status == egw_pkg::ST_FIRED_NONE)
    |-> res_pending == '0)
    else $error("Pending mask not cleared on firing.");

  a_task_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != egw_pkg::ST_RELEASED |-> res_task == '0)
    else $error("Released task set on a non-release result.");
endmodule

bind event_group_waiter_release_unit egw_checker #(
  .EVENT_BITS  (EVENT_BITS),
  .TASK_ID_BITS(TASK_ID_BITS)
) u_egw_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_task   (res.released_task),
  .res_pending(res.pending_events),
  .res_last   (res.last)
);
